// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_dpath, sorted_priority_queue and spq_checker.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DEQ_POP,
        S_ENQ_RD,
        S_ENQ_CMP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    set_pos;
        logic    rd_head;
        logic    rd_prev;
        logic    move_up;
        logic    write_new;
        logic    pop;
        logic    set_status;
        status_t status_code;
        logic    emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_deq;
        logic empty;
        logic full;
        logic pos_zero;
        logic prev_gt;
        logic out_free;
    } ctl_stat_t;

endpackage

// ===== src/spq_ctrl.sv =====
// Sequencer for the sorted priority queue: decodes each item and steps the
// insertion walk. Depends on spq_pkg.
module spq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  spq_pkg::ctl_stat_t stat,
    output spq_pkg::ctl_cmd_t  cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status_code = ST_OK;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_deq)
                begin
                    if (stat.empty)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_EMPTY;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = S_DEQ_POP;
                    end
                end
                else if (stat.full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_FULL;
                    state_next      = S_RESP;
                end
                else
                begin
                    cmd.set_pos = 1'b1;
                    state_next  = S_ENQ_RD;
                end
            end
            S_DEQ_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_RESP;
            end
            S_ENQ_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.write_new = 1'b1;
                    state_next    = S_RESP;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_ENQ_CMP;
                end
            end
            S_ENQ_CMP:
            begin
                if (stat.prev_gt)
                begin
                    cmd.move_up = 1'b1;
                    state_next  = S_ENQ_RD;
                end
                else
                begin
                    cmd.write_new = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/spq_dpath.sv =====
// Datapath of the sorted priority queue: circular entry memory, head and
// count, insertion walk pointer and the output register. Depends on spq_pkg.
module spq_dpath
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((35 + CW + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         in_data,
    input  logic                in_action,
    input  spq_pkg::ctl_cmd_t   cmd,
    output spq_pkg::ctl_stat_t  stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_W-1:0]    out_data
);
    import spq_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    logic [2*DATA_W-1:0] mem [CAPACITY];

    logic [DATA_W-1:0]   item_value_reg;
    logic [DATA_W-1:0]   item_rank_reg;
    logic                action_reg;
    logic [IW-1:0]       head_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       pos_reg;
    logic [2*DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0]   res_value_reg;
    status_t             status_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   o_value_reg;
    status_t             o_status_reg;
    logic [CW-1:0]       o_count_reg;

    logic [CW-1:0]       lidx;
    logic [IW:0]         psum;
    logic [IW-1:0]       paddr;
    logic                rd_en;
    logic                wr_en;
    logic [2*DATA_W-1:0] wr_data;

    always_comb
    begin
        if (cmd.rd_head)
        begin
            lidx = '0;
        end
        else if (cmd.rd_prev)
        begin
            lidx = pos_reg - CW'(1);
        end
        else
        begin
            lidx = pos_reg;
        end
        psum = {1'b0, head_reg} + {1'b0, lidx[IW-1:0]};
        if (psum >= (IW+1)'(CAPACITY))
        begin
            psum = psum - (IW+1)'(CAPACITY);
        end
        paddr   = psum[IW-1:0];
        rd_en   = cmd.rd_head | cmd.rd_prev;
        wr_en   = cmd.move_up | cmd.write_new;
        wr_data = cmd.move_up ? rd_data_reg : {item_rank_reg, item_value_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[paddr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[paddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_value_reg <= in_data[DATA_W-1:0];
            item_rank_reg  <= in_data[2*DATA_W-1:DATA_W];
            action_reg     <= in_action;
        end
        if (cmd.emit)
        begin
            o_value_reg  <= res_value_reg;
            o_status_reg <= status_reg;
            o_count_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            res_value_reg <= '1;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                res_value_reg <= '1;
                status_reg    <= ST_OK;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.set_pos)
            begin
                pos_reg <= count_reg;
            end
            else if (cmd.move_up)
            begin
                pos_reg <= pos_reg - CW'(1);
            end
            if (cmd.write_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg     <= count_reg - CW'(1);
                res_value_reg <= rd_data_reg[DATA_W-1:0];
                head_reg      <= (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + IW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.is_deq   = (action_reg == ACT_DEQ);
        stat.empty    = (count_reg == '0);
        stat.full     = (count_reg == CW'(CAPACITY));
        stat.pos_zero = (pos_reg == '0);
        stat.prev_gt  = $signed(rd_data_reg[2*DATA_W-1:DATA_W]) > $signed(item_rank_reg);
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_W'({o_count_reg, (o_count_reg == '0), o_status_reg, o_value_reg});

endmodule

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue: entries leave by ascending signed rank, FIFO among equals.
// Dequeue reads and pops the head entry; dequeue when empty or enqueue when full only
// sets the status. Enqueue walks from the tail, shifting each entry of greater rank back
// a place, each step reading an entry then comparing it. One item at a time: the next is
// accepted as the result beat is raised. A stalled earlier result beat holds the response.
// Async active-low reset empties the queue; memory needs no clearing; uses spq_ctrl, spq_dpath.
module sorted_priority_queue
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((35 + CW + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,  // item_value[31:0], rank[63:32]
    input  logic             s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // out_value, status, now_empty, occupancy
);
    import spq_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    spq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_dpath
    #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .OUT_W    (OUT_W)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_action (s_axis_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== src/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((35 + CW + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);
    import spq_pkg::*;

    logic [31:0]   o_value;
    logic [1:0]    o_status;
    logic          o_empty;
    logic [CW-1:0] o_count;

    assign o_value  = m_axis_tdata[31:0];
    assign o_status = m_axis_tdata[33:32];
    assign o_empty  = m_axis_tdata[34];
    assign o_count  = m_axis_tdata[35+CW-1:35];

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (o_count <= CW'(CAPACITY)))
        else $error("occupancy above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (o_empty == (o_count == '0)))
        else $error("now_empty disagrees with occupancy");

    a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && o_status == ST_EMPTY) |-> (o_value == '1 && o_empty))
        else $error("empty dequeue beat malformed");

    a_full_enq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && o_status == ST_FULL) |-> (o_count == CW'(CAPACITY) && o_value == '1))
        else $error("full drop beat malformed");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind sorted_priority_queue spq_checker
#(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .OUT_W    (OUT_W)
)
u_spq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
